// ===== rtl/tgd_pkg.sv =====
package tgd_pkg;

    // Operation codes of an input word
    localparam logic [1:0] OP_CHANGE = 2'd0;
    localparam logic [1:0] OP_INIT   = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;
    localparam logic [1:0] OP_NONE   = 2'd3;

    // Result kinds and the glitch value code
    localparam logic       KIND_APPEND  = 1'b0;
    localparam logic       KIND_REWRITE = 1'b1;
    localparam logic [2:0] GLITCH_CODE  = 3'd4;

    // Field widths
    localparam int TIME_W   = 64;
    localparam int SIG_W    = 8;
    localparam int VAL_W    = 2;
    localparam int OVAL_W   = 3;
    localparam int OP_W     = 2;
    localparam int WINDOW_W = 32;

    // Per-signal state record held in the state memory
    typedef struct packed {
        logic [TIME_W-1:0] emitted_time;
        logic [TIME_W-1:0] change_time;
        logic              change_time_valid;
        logic              glitching;
        logic [VAL_W-1:0]  held_value;
        logic              has_output;
    } tgd_rec_t;

    localparam int REC_W = $bits(tgd_rec_t);

    localparam tgd_rec_t REC_RESET = '{
        emitted_time:      {TIME_W{1'b1}},
        change_time:       '0,
        change_time_valid: 1'b0,
        glitching:         1'b0,
        held_value:        '0,
        has_output:        1'b0
    };

    // One result word
    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] out_time;
        logic [SIG_W-1:0]  out_signal;
        logic [OVAL_W-1:0] out_value;
        logic              last;
    } tgd_result_t;

endpackage

// ===== rtl/tgd_if.sv =====
interface tgd_in_if import tgd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [TIME_W-1:0] event_time;
    logic [SIG_W-1:0]  signal_index;
    logic [VAL_W-1:0]  new_value;
    logic [VAL_W-1:0]  previous_value;

    modport source (
        output valid, operation, event_time, signal_index, new_value, previous_value,
        input  ready
    );
    modport sink (
        input  valid, operation, event_time, signal_index, new_value, previous_value,
        output ready
    );
endinterface

interface tgd_out_if import tgd_pkg::*;;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [TIME_W-1:0] out_time;
    logic [SIG_W-1:0]  out_signal;
    logic [OVAL_W-1:0] out_value;
    logic              last;

    modport source (
        output valid, kind, out_time, out_signal, out_value, last,
        input  ready
    );
    modport sink (
        input  valid, kind, out_time, out_signal, out_value, last,
        output ready
    );
endinterface

interface tgd_cfg_if import tgd_pkg::*;;
    logic                valid;
    logic                ready;
    logic [WINDOW_W-1:0] glitch_window;

    modport source (
        output valid, glitch_window,
        input  ready
    );
    modport sink (
        input  valid, glitch_window,
        output ready
    );
endinterface

// ===== rtl/tgd_ram.sv =====
module tgd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/tgd_update.sv =====
module tgd_update import tgd_pkg::*; (
    input  logic [OP_W-1:0]     op,
    input  logic [TIME_W-1:0]   t,
    input  logic [SIG_W-1:0]    sig,
    input  logic [VAL_W-1:0]    v,
    input  logic [VAL_W-1:0]    p,
    input  logic [WINDOW_W-1:0] window,
    input  tgd_rec_t            rec_in,
    output tgd_rec_t            rec_out,
    output tgd_result_t         res0,
    output tgd_result_t         res1,
    output logic [1:0]          n_res
);

    logic [TIME_W-1:0] since_change;
    logic              same_time;
    logic              in_window;
    logic              differs;

    assign since_change = t - rec_in.change_time;
    assign same_time    = (t == rec_in.emitted_time);
    assign in_window    = (window != '0) && rec_in.change_time_valid
                          && (since_change < {{(TIME_W-WINDOW_W){1'b0}}, window});
    assign differs      = (v != p);

    // Work out the new record and up to two results
    always_comb
    begin
        rec_out = rec_in;
        n_res   = 2'd0;
        res0    = '{kind: KIND_APPEND, out_time: t, out_signal: sig,
                    out_value: {1'b0, v}, last: 1'b0};
        res1    = '{kind: KIND_APPEND, out_time: t, out_signal: sig,
                    out_value: {1'b0, v}, last: 1'b1};
        case (op)
            OP_CHANGE:
            begin
                if (same_time)
                begin
                    // rewrite the last emitted transition in place
                    if (rec_in.has_output)
                    begin
                        res0.kind     = KIND_REWRITE;
                        res0.out_time = rec_in.emitted_time;
                        n_res         = 2'd1;
                    end
                end
                else if (in_window)
                begin
                    // mark the previous transition as a glitch once
                    if (differs && !rec_in.glitching)
                    begin
                        if (rec_in.has_output)
                        begin
                            res0.kind      = KIND_REWRITE;
                            res0.out_time  = rec_in.emitted_time;
                            res0.out_value = GLITCH_CODE;
                            n_res          = 2'd1;
                        end
                        rec_out.glitching = 1'b1;
                    end
                end
                else if (differs || rec_in.glitching)
                begin
                    if (rec_in.glitching)
                    begin
                        // close the open glitch at the last change time
                        res0.out_time        = rec_in.change_time;
                        res0.out_value       = {1'b0, p};
                        rec_out.emitted_time = rec_in.change_time;
                        rec_out.has_output   = 1'b1;
                        rec_out.glitching    = 1'b0;
                        n_res                = 2'd1;
                        if (differs)
                        begin
                            n_res = 2'd2;
                        end
                    end
                    else
                    begin
                        n_res = 2'd1;
                    end
                    if (differs)
                    begin
                        rec_out.emitted_time = t;
                        rec_out.has_output   = 1'b1;
                    end
                end
                rec_out.change_time       = t;
                rec_out.change_time_valid = 1'b1;
                rec_out.held_value        = v;
            end
            OP_INIT:
            begin
                n_res                     = 2'd1;
                rec_out.has_output        = 1'b1;
                rec_out.emitted_time      = t;
                rec_out.change_time       = t;
                rec_out.change_time_valid = 1'b1;
                rec_out.held_value        = v;
                rec_out.glitching         = 1'b0;
            end
            OP_FLUSH:
            begin
                if (rec_in.glitching)
                begin
                    if (rec_in.has_output)
                    begin
                        res0.out_time  = rec_in.change_time;
                        res0.out_value = {1'b0, rec_in.held_value};
                        n_res          = 2'd1;
                    end
                    rec_out.glitching    = 1'b0;
                    rec_out.emitted_time = rec_in.change_time;
                end
            end
            default:
            begin
                n_res = 2'd0;
            end
        endcase
        res0.last = (n_res == 2'd1);
    end

endmodule

// ===== rtl/transition_glitch_decimator.sv =====
// Results pass the update stage registers and the result queue. Throughput: one
// word per cycle while each word makes at most one result and the output is
// ready; the output drains one result per cycle, so two-result words take two
// output slots. The per-signal state lives in one memory, read once per word and
// written back by all but OP_NONE and out-of-range words. Reset: a clearing pass
// fills state memory, input ready low until it ends; glitch window resets to 0.
module transition_glitch_decimator import tgd_pkg::*; #(
    parameter int NUM_SIGNALS = 256
) (
    input  logic      clk,
    input  logic      rst_n,
    tgd_in_if.sink    events,
    tgd_out_if.source transitions,
    tgd_cfg_if.sink   cfg
);

    localparam int AW      = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
    localparam int Q_DEPTH = 4;
    localparam int QW      = $clog2(Q_DEPTH);

    // Configuration register
    logic [WINDOW_W-1:0] window_reg;

    // Clearing pass
    logic          clr_active_reg;
    logic [AW-1:0] clr_addr_reg;

    // Update stage
    logic              s1_valid_reg;
    logic [OP_W-1:0]   s1_op_reg;
    logic [TIME_W-1:0] s1_time_reg;
    logic [SIG_W-1:0]  s1_sig_reg;
    logic [AW-1:0]     s1_addr_reg;
    logic [VAL_W-1:0]  s1_new_reg;
    logic [VAL_W-1:0]  s1_prev_reg;
    logic              fwd_reg;
    tgd_rec_t          fwd_rec_reg;

    // Result queue
    tgd_result_t q_mem_reg [Q_DEPTH];
    logic [QW-1:0] head_reg;
    logic [QW-1:0] tail_reg;
    logic [QW:0]   count_reg;

    logic [AW+SIG_W-1:0] idx_ext;
    logic [AW-1:0]       in_addr;
    logic                in_range;
    logic                accept;
    logic                advance;
    logic                s1_we;
    logic                pop;
    logic [REC_W-1:0]    ram_rdata;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    tgd_rec_t            ram_wdata;
    tgd_rec_t            rec_cur;
    tgd_rec_t            rec_new;
    tgd_result_t         res0;
    tgd_result_t         res1;
    logic [1:0]          n_res;
    logic [1:0]          n_push;

    // Decode the incoming word
    assign idx_ext  = (AW+SIG_W)'(events.signal_index);
    assign in_addr  = idx_ext[AW-1:0];
    assign in_range = ({1'b0, idx_ext} < (AW+SIG_W+1)'(NUM_SIGNALS));

    // Advance the update stage when the queue has room for two results
    assign advance      = s1_valid_reg && (count_reg <= (QW+1)'(Q_DEPTH - 2));
    assign events.ready = !clr_active_reg && (!s1_valid_reg || advance);
    assign accept       = events.valid && events.ready;
    assign s1_we        = advance && (s1_op_reg != OP_NONE);

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= '0;
        end
        else if (cfg.valid)
        begin
            window_reg <= cfg.glitch_window;
        end
    end

    // Sweep the state memory after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == AW'(NUM_SIGNALS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    assign ram_we    = clr_active_reg || s1_we;
    assign ram_waddr = clr_active_reg ? clr_addr_reg : s1_addr_reg;
    assign ram_wdata = clr_active_reg ? REC_RESET : rec_new;

    tgd_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_SIGNALS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (in_addr),
        .rdata (ram_rdata)
    );

    // Take the record just written when the read raced the write
    assign rec_cur = fwd_reg ? fwd_rec_reg : tgd_rec_t'(ram_rdata);

    tgd_update u_update (
        .op      (s1_op_reg),
        .t       (s1_time_reg),
        .sig     (s1_sig_reg),
        .v       (s1_new_reg),
        .p       (s1_prev_reg),
        .window  (window_reg),
        .rec_in  (rec_cur),
        .rec_out (rec_new),
        .res0    (res0),
        .res1    (res1),
        .n_res   (n_res)
    );

    // Update stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
            fwd_reg      <= s1_we && (s1_addr_reg == in_addr);
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Update stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= in_range ? events.operation : OP_NONE;
            s1_time_reg <= events.event_time;
            s1_sig_reg  <= events.signal_index;
            s1_addr_reg <= in_addr;
            s1_new_reg  <= events.new_value;
            s1_prev_reg <= events.previous_value;
            fwd_rec_reg <= rec_new;
        end
    end

    // Result queue
    assign n_push = advance ? n_res : 2'd0;
    assign pop    = transitions.valid && transitions.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            tail_reg  <= tail_reg + QW'(n_push);
            head_reg  <= head_reg + QW'(pop);
            count_reg <= count_reg + (QW+1)'(n_push) - (QW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (n_push != 2'd0)
        begin
            q_mem_reg[tail_reg] <= res0;
        end
        if (n_push == 2'd2)
        begin
            q_mem_reg[tail_reg + 1'b1] <= res1;
        end
    end

    // Drive the output word from the queue head
    assign transitions.valid      = (count_reg != '0);
    assign transitions.kind       = q_mem_reg[head_reg].kind;
    assign transitions.out_time   = q_mem_reg[head_reg].out_time;
    assign transitions.out_signal = q_mem_reg[head_reg].out_signal;
    assign transitions.out_value  = q_mem_reg[head_reg].out_value;
    assign transitions.last       = q_mem_reg[head_reg].last;

endmodule
